// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the median and smoothing filter RTL.
// Each macro expects clk and rst_n to be visible in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside of reset.
`define M5E_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every clock edge, including while reset is asserted.
`define M5E_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/m5e_pkg.sv =====
// Shared types and constants for the median-of-five filter with moving average.
// No dependencies; every RTL module imports this package.
package m5e_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int FRAC_BITS   = 10;
    localparam int WEIGHT_BITS = 11;
    localparam int LEVEL_BITS  = SAMPLE_BITS + FRAC_BITS;
    localparam int PROD_BITS   = LEVEL_BITS + WEIGHT_BITS;
    localparam int MW_BITS     = SAMPLE_BITS + WEIGHT_BITS;
    localparam int ACC_BITS    = PROD_BITS + 1;
    localparam int WINDOW      = 5;
    localparam int RANK_BITS   = $clog2(WINDOW);
    localparam int CHANNELS    = 2;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [WEIGHT_BITS-1:0] weight_t;
    typedef logic [LEVEL_BITS-1:0]  level_t;
    typedef logic [RANK_BITS-1:0]   rank_t;

    localparam rank_t   MEDIAN_RANK  = rank_t'(WINDOW / 2);
    localparam weight_t WEIGHT_ONE   = weight_t'(1024);
    localparam weight_t WEIGHT_RESET = weight_t'(307);

    typedef struct packed {
        sample_t median;
        logic    channel;
        logic    raw_mode;
    } item_t;

endpackage

// ===== rtl/median5_ema_sensor_filter_top.sv =====
// Top level of the median-of-five filter with per-channel moving average; depends on
// m5e_pkg, m5e_rank_lane, m5e_merge, m5e_ema_unit and assert_macros.svh. The block takes
// one window of five samples per cycle while sample_stall is low and passes it through the
// first stage, the smoothing stage and the output register that drives result_valid, with
// one result per cycle sustained while result_stall is low; that rate is set by the single
// multiply-add in the smoothing stage, which closes on the channel's level register each
// cycle. Five comparison lanes rank the samples and a merge stage picks the median. The
// weight register saturates at 1024 on write and should only be written while the block
// holds no transaction in flight.
`include "assert_macros.svh"

module median5_ema_sensor_filter_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  m5e_pkg::weight_t  new_sample_weight,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  m5e_pkg::sample_t  sample_first,
    input  m5e_pkg::sample_t  sample_second,
    input  m5e_pkg::sample_t  sample_third,
    input  m5e_pkg::sample_t  sample_fourth,
    input  m5e_pkg::sample_t  sample_fifth,
    input  logic              channel,
    input  logic              raw_mode,
    output logic              result_valid,
    input  logic              result_stall,
    output m5e_pkg::sample_t  filtered_value
);
    import m5e_pkg::*;

    weight_t              weight_reg;
    weight_t              weight_next;
    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    item_t                s1_item_reg;
    item_t                s1_item_next;

    sample_t              samples [WINDOW];
    sample_t              lane_others [WINDOW][WINDOW-1];
    logic [WINDOW-2:0]    lane_earlier [WINDOW];
    logic [WINDOW-1:0]    lane_hit;
    sample_t              median;
    logic                 item_stall;
    logic                 s1_free;

    assign cfg_ready = 1'b1;

    assign samples[0] = sample_first;
    assign samples[1] = sample_second;
    assign samples[2] = sample_third;
    assign samples[3] = sample_fourth;
    assign samples[4] = sample_fifth;

    for (genvar gi = 0; gi < WINDOW; gi++)
    begin : g_lane
        for (genvar gk = 0; gk < WINDOW - 1; gk++)
        begin : g_other
            assign lane_others[gi][gk]  = samples[(gk < gi) ? gk : gk + 1];
            assign lane_earlier[gi][gk] = (gk < gi) ? 1'b1 : 1'b0;
        end

        m5e_rank_lane u_lane (
            .own       (samples[gi]),
            .others    (lane_others[gi]),
            .earlier   (lane_earlier[gi]),
            .is_median (lane_hit[gi])
        );
    end

    m5e_merge u_merge (
        .samples (samples),
        .hit     (lane_hit),
        .median  (median)
    );

    assign s1_free      = !s1_valid_reg || !item_stall;
    assign sample_stall = !s1_free;

    always_comb
    begin
        weight_next = weight_reg;
        if (cfg_valid && cfg_ready)
        begin
            weight_next = (new_sample_weight > WEIGHT_ONE) ? WEIGHT_ONE : new_sample_weight;
        end
        s1_valid_next         = s1_free ? sample_valid : s1_valid_reg;
        s1_item_next.median   = median;
        s1_item_next.channel  = channel;
        s1_item_next.raw_mode = raw_mode;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg   <= WEIGHT_RESET;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            weight_reg   <= weight_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free && sample_valid)
        begin
            s1_item_reg <= s1_item_next;
        end
    end

    m5e_ema_unit u_ema (
        .clk            (clk),
        .rst_n          (rst_n),
        .weight         (weight_reg),
        .item_valid     (s1_valid_reg),
        .item           (s1_item_reg),
        .item_stall     (item_stall),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .filtered_value (filtered_value)
    );

    `M5E_ASSERT(a_one_median, $onehot(lane_hit), "median select is not one-hot")
    `M5E_ASSERT(a_s1_hold, (s1_valid_reg && item_stall) |=> (s1_valid_reg && $stable(s1_item_reg)), "first stage lost a waiting transaction")
    `M5E_ASSERT(a_weight_range, weight_reg <= WEIGHT_ONE, "weight register above full scale")

endmodule

// ===== rtl/m5e_rank_lane.sv =====
// One comparison lane: ranks its own sample against the other four of the window.
// Depends on m5e_pkg. Ties are broken by window position so the ranks form a permutation.
module m5e_rank_lane (
    input  m5e_pkg::sample_t                      own,
    input  m5e_pkg::sample_t                      others [m5e_pkg::WINDOW-1],
    input  logic [m5e_pkg::WINDOW-2:0]            earlier,
    output logic                                  is_median
);
    import m5e_pkg::*;

    rank_t rank;

    always_comb
    begin
        rank = '0;
        for (int k = 0; k < WINDOW - 1; k++)
        begin
            if (earlier[k] ? (others[k] <= own) : (others[k] < own))
            begin
                rank = rank + rank_t'(1);
            end
        end
    end

    assign is_median = (rank == MEDIAN_RANK);

endmodule

// ===== rtl/m5e_merge.sv =====
// Merging stage: picks the sample whose lane reports the middle rank.
// Depends on m5e_pkg; the select is one-hot by construction of the lanes.
module m5e_merge (
    input  m5e_pkg::sample_t               samples [m5e_pkg::WINDOW],
    input  logic [m5e_pkg::WINDOW-1:0]     hit,
    output m5e_pkg::sample_t               median
);
    import m5e_pkg::*;

    always_comb
    begin
        median = '0;
        for (int i = 0; i < WINDOW; i++)
        begin
            median = median | (samples[i] & {SAMPLE_BITS{hit[i]}});
        end
    end

endmodule

// ===== rtl/m5e_ema_unit.sv =====
// Smoothing pipeline: weight multiply, per-channel moving-average update and output register.
// Depends on m5e_pkg and assert_macros.svh.
`include "assert_macros.svh"

module m5e_ema_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  m5e_pkg::weight_t  weight,
    input  logic              item_valid,
    input  m5e_pkg::item_t    item,
    output logic              item_stall,
    output logic              result_valid,
    input  logic              result_stall,
    output m5e_pkg::sample_t  filtered_value
);
    import m5e_pkg::*;

    logic                 s2_valid_reg;
    logic                 s2_valid_next;
    item_t                s2_item_reg;
    logic [MW_BITS-1:0]   s2_mw_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    sample_t              filtered_reg;
    sample_t              filtered_next;
    level_t               level_reg [CHANNELS];
    level_t               level_next;

    logic                 out_free;
    logic                 s2_free;
    logic                 commit;
    weight_t              inv_weight;
    logic [PROD_BITS-1:0] prod;
    logic [ACC_BITS-1:0]  acc;

    assign out_free   = !out_valid_reg || !result_stall;
    assign s2_free    = !s2_valid_reg || out_free;
    assign item_stall = !s2_free;
    assign commit     = s2_valid_reg && out_free && !s2_item_reg.raw_mode;

    assign inv_weight = WEIGHT_ONE - weight;
    assign prod       = PROD_BITS'(level_reg[s2_item_reg.channel]) * PROD_BITS'(inv_weight);
    assign acc        = ACC_BITS'(prod) + (ACC_BITS'(s2_mw_reg) << FRAC_BITS);
    assign level_next = acc[FRAC_BITS +: LEVEL_BITS];

    always_comb
    begin
        s2_valid_next  = s2_free ? item_valid : s2_valid_reg;
        out_valid_next = out_free ? s2_valid_reg : out_valid_reg;
        if (s2_item_reg.raw_mode)
        begin
            filtered_next = s2_item_reg.median;
        end
        else
        begin
            filtered_next = level_next[FRAC_BITS +: SAMPLE_BITS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            level_reg[0]  <= '0;
            level_reg[1]  <= '0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
            if (commit)
            begin
                level_reg[s2_item_reg.channel] <= level_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_free && item_valid)
        begin
            s2_item_reg <= item;
            s2_mw_reg   <= MW_BITS'(item.median) * MW_BITS'(weight);
        end
        if (out_free && s2_valid_reg)
        begin
            filtered_reg <= filtered_next;
        end
    end

    assign result_valid   = out_valid_reg;
    assign filtered_value = filtered_reg;

    `M5E_ASSERT(a_level0_hold, !(commit && !s2_item_reg.channel) |=> $stable(level_reg[0]), "channel 0 level changed without a smoothing transaction")
    `M5E_ASSERT(a_raw_passthru, (s2_valid_reg && out_free && s2_item_reg.raw_mode) |=> (filtered_reg == $past(s2_item_reg.median)), "raw transaction did not return its median")
    `M5E_ASSERT(a_out_from_level, commit |=> (filtered_reg == level_reg[$past(s2_item_reg.channel)][FRAC_BITS +: SAMPLE_BITS]), "smoothed output differs from stored level")

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for median5_ema_sensor_filter_top: directed and random windows.
// Depends on m5e_pkg and the filter RTL; predicts each filtered value and checks it in order.

module testbench;
    import m5e_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 4;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 168;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    cfg_valid;
    logic    cfg_ready;
    weight_t new_sample_weight;
    logic    sample_valid;
    logic    sample_stall;
    sample_t sample_first;
    sample_t sample_second;
    sample_t sample_third;
    sample_t sample_fourth;
    sample_t sample_fifth;
    logic    channel;
    logic    raw_mode;
    logic    result_valid;
    logic    result_stall = 1'b0;
    sample_t filtered_value;

    sample_t pending_outputs[$];
    level_t  smoothed_levels[CHANNELS];
    weight_t weight_setting;
    int      error_count = 0;
    int      idle_cycles = 0;
    bit      idling_on = 1'b1;

    median5_ema_sensor_filter_top dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .new_sample_weight (new_sample_weight),
        .sample_valid      (sample_valid),
        .sample_stall      (sample_stall),
        .sample_first      (sample_first),
        .sample_second     (sample_second),
        .sample_third      (sample_third),
        .sample_fourth     (sample_fourth),
        .sample_fifth      (sample_fifth),
        .channel           (channel),
        .raw_mode          (raw_mode),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .filtered_value    (filtered_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        result_stall <= idling_on && ($urandom_range(0, 99) < 6);
    end

    function automatic sample_t median_of_window(sample_t a, sample_t b, sample_t c,
                                                 sample_t d, sample_t e);
        sample_t v[WINDOW];
        sample_t t;
        v[0] = a;
        v[1] = b;
        v[2] = c;
        v[3] = d;
        v[4] = e;
        for (int i = 0; i < WINDOW; i++)
            for (int j = i + 1; j < WINDOW; j++)
                if (v[j] < v[i])
                begin
                    t    = v[i];
                    v[i] = v[j];
                    v[j] = t;
                end
        return v[2];
    endfunction

    function automatic sample_t filter_window(sample_t a, sample_t b, sample_t c,
                                              sample_t d, sample_t e, logic ch, logic raw);
        sample_t     med;
        weight_t     w;
        logic [63:0] acc;
        med = median_of_window(a, b, c, d, e);
        if (raw)
            return med;
        w   = (weight_setting > WEIGHT_ONE) ? WEIGHT_ONE : weight_setting;
        acc = 64'(smoothed_levels[ch]) * 64'(WEIGHT_ONE - w)
            + ((64'(med) * 64'(w)) << FRAC_BITS);
        smoothed_levels[ch] = level_t'(acc >> FRAC_BITS);
        return sample_t'(smoothed_levels[ch] >> FRAC_BITS);
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            smoothed_levels[0] = '0;
            smoothed_levels[1] = '0;
            weight_setting     = WEIGHT_RESET;
            idle_cycles        = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                weight_setting = new_sample_weight;
            if (sample_valid && !sample_stall)
                pending_outputs.push_back(filter_window(sample_first, sample_second,
                    sample_third, sample_fourth, sample_fifth, channel, raw_mode));
            if (result_valid && !result_stall)
            begin
                if (pending_outputs.size() == 0)
                begin
                    $display("%0t: unexpected transaction, expected none, actual %0d",
                             $time, filtered_value);
                    error_count++;
                end
                else if (pending_outputs[0] !== filtered_value)
                begin
                    $display("%0t: filtered_value expected %0d actual %0d",
                             $time, pending_outputs[0], filtered_value);
                    error_count++;
                    void'(pending_outputs.pop_front());
                end
                else
                    void'(pending_outputs.pop_front());
            end
            if ((cfg_valid && cfg_ready) || (sample_valid && !sample_stall)
                || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("median5_ema_sensor_filter_top verification failed");
                $finish;
            end
        end
    end

    task automatic send_window(sample_t a, sample_t b, sample_t c, sample_t d, sample_t e,
                               logic ch, logic raw);
        if (idling_on && $urandom_range(0, 99) < 6)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_first  <= a;
        sample_second <= b;
        sample_third  <= c;
        sample_fourth <= d;
        sample_fifth  <= e;
        channel       <= ch;
        raw_mode      <= raw;
        sample_valid  <= 1'b1;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        sample_valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_weight(weight_t w);
        wait_drained();
        new_sample_weight <= w;
        cfg_valid         <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed_windows();
        send_window(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0, 1'b0);
        send_window(12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b0, 1'b0);
        send_window(12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095, 1'b1, 1'b0);
        send_window(12'd5, 12'd1, 12'd4, 12'd2, 12'd3, 1'b0, 1'b1);
        send_window(12'd100, 12'd100, 12'd7, 12'd100, 12'd9, 1'b1, 1'b1);
        send_window(12'd4095, 12'd4095, 12'd0, 12'd0, 12'd1, 1'b0, 1'b0);
        send_window(12'd10, 12'd20, 12'd30, 12'd40, 12'd50, 1'b1, 1'b0);
        send_window(12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1, 1'b1);
        send_window(12'd2730, 12'd1365, 12'd2730, 12'd1365, 12'd2048, 1'b0, 1'b0);
    endtask

    task automatic test_weight_extremes();
        write_weight(11'd0);
        send_window(12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b0, 1'b0);
        send_window(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b1, 1'b0);
        write_weight(11'd1024);
        send_window(12'd4095, 12'd3000, 12'd4095, 12'd17, 12'd4095, 1'b0, 1'b0);
        send_window(12'd1, 12'd2, 12'd3, 12'd4, 12'd5, 1'b1, 1'b0);
        write_weight(11'd2047);
        send_window(12'd0, 12'd0, 12'd4095, 12'd0, 12'd0, 1'b0, 1'b0);
        send_window(12'd4095, 12'd4094, 12'd4093, 12'd4092, 12'd4091, 1'b1, 1'b0);
        write_weight(11'd1025);
        send_window(12'd777, 12'd777, 12'd777, 12'd0, 12'd4095, 1'b0, 1'b0);
        write_weight(11'd1);
        send_window(12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b0, 1'b0);
        send_window(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b1, 1'b0);
        write_weight(11'd1023);
        send_window(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0, 1'b0);
        send_window(12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1, 1'b0);
    endtask

    task automatic test_random_windows();
        sample_t win[WINDOW];
        sample_t base;
        weight_t w;
        int      kind;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: w = WEIGHT_RESET;
                1: w = 11'd0;
                2: w = WEIGHT_ONE;
                3: w = 11'd2047;
                4: w = 11'd717;
                5: w = 11'd1;
                6: w = weight_t'($urandom_range(1025, 2047));
                default: w = weight_t'($urandom_range(0, 1024));
            endcase
            write_weight(w);
            idling_on = (phase != 4);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                kind = $urandom_range(0, 9);
                base = sample_t'($urandom);
                for (int k = 0; k < WINDOW; k++)
                    case (kind)
                        5, 6: win[k] = ($urandom_range(0, 1) != 0)
                                     ? 12'd4095 - 12'($urandom_range(0, 1))
                                     : 12'($urandom_range(0, 1));
                        7, 8: win[k] = base ^ 12'($urandom_range(0, 1));
                        9: win[k] = 12'($urandom_range(0, 15));
                        default: win[k] = sample_t'($urandom);
                    endcase
                send_window(win[0], win[1], win[2], win[3], win[4],
                            1'($urandom_range(0, 1)), $urandom_range(0, 99) < 20);
            end
            idling_on = 1'b1;
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        cfg_valid         = 1'b0;
        new_sample_weight = '0;
        sample_valid      = 1'b0;
        sample_first      = '0;
        sample_second     = '0;
        sample_third      = '0;
        sample_fourth     = '0;
        sample_fifth      = '0;
        channel           = 1'b0;
        raw_mode          = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed_windows();
        test_weight_extremes();
        test_random_windows();
        wait_drained();
        if (error_count == 0 && pending_outputs.size() == 0)
            $display("median5_ema_sensor_filter_top verification clean");
        else
            $display("median5_ema_sensor_filter_top verification failed");
        $finish;
    end
endmodule
